[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/stb_pkg.sv]
// types and constants of the software timer bank
package stb_pkg;

   // bank size and derived widths
   localparam int NUM_TIMERS = 16;
   localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int PTR_W      = $clog2(NUM_TIMERS + 1);

   // transaction field widths
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 4;
   localparam int DELAY_W  = 16;

   // width wide enough for both a timer index and a memory address
   localparam int CMP_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_POLL  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_SET   = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic               armed;
      logic [DELAY_W-1:0] remaining;
   } entry_type;

endpackage

[rtl/core/stb_if.sv]
// valid/ready channels of the software timer bank

// request channel: one command per transaction
interface stb_req_if;
   import stb_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [INDEX_W-1:0]  timer_index;
   logic [DELAY_W-1:0]  delay_ticks;

   modport source (output valid, output action, output timer_index, output delay_ticks,
                   input ready);
   modport sink   (input valid, input action, input timer_index, input delay_ticks,
                   output ready);
endinterface

// response channel: one expired timer per transaction
interface stb_rsp_if;
   import stb_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] fired_index;
   logic               last_fired;

   modport source (output valid, output fired_index, output last_fired, input ready);
   modport sink   (input valid, input fired_index, input last_fired, output ready);
endinterface

[rtl/core/software_timer_bank.sv]
// bank of one-shot countdown timers held in a synchronous memory
//
//   channel    direction  carries
//   req_chan   in         action, timer_index, delay_ticks
//   rsp_chan   out        fired_index, last_fired (one per expired timer)
//
// a set or clear writes the entry at the accepting edge
// a tick or poll sweeps the memory one entry a cycle while not stalled, read then write back,
// then flushes; no new request is accepted until the block is back in idle
// each expiry is held back in a pending register so that the final one can be marked last
// the sweep stalls while an expiry waits and the response register is full
// reset clears the per-entry valid flags at once; no clearing pass is needed
module software_timer_bank (
   input  logic          clock,
   input  logic          reset,
   stb_req_if.sink       req_chan,
   stb_rsp_if.source     rsp_chan
);
   import stb_pkg::*;

   // timer store and its per-entry valid flags
   entry_type               mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]   ent_valid_ff;
   entry_type               mem_rdata_ff;
   logic                    rd_vld_ff;

   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   entry_type               mem_wdata;
   logic [ADDR_W-1:0]       rd_addr;

   // control state
   state_type               state_ff, state_in;
   logic [PTR_W-1:0]        scan_ptr_ff, scan_ptr_in;
   logic                    proc_valid_ff, proc_valid_in;
   logic [ADDR_W-1:0]       proc_idx_ff, proc_idx_in;
   logic                    tick_ff, tick_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [INDEX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                    rsp_last_ff, rsp_last_in;

   // decoded request and datapath signals
   logic                    req_accept;
   action_type              req_action;
   logic [CMP_W-1:0]        req_idx_ext;
   logic                    req_idx_ok;
   logic                    out_free;
   logic                    scan_done;
   entry_type               cur;
   logic                    dec;
   logic [DELAY_W-1:0]      new_rem;
   logic                    fire;
   logic                    stall;
   logic [CMP_W-1:0]        proc_idx_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_action     = action_type'(req_chan.action);
   assign req_idx_ext    = CMP_W'(req_chan.timer_index);
   assign req_idx_ok     = (req_idx_ext < CMP_W'(NUM_TIMERS));

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.fired_index = rsp_index_ff;
   assign rsp_chan.last_fired  = rsp_last_ff;

   // entry being processed, reset value where never written
   assign cur          = rd_vld_ff ? mem_rdata_ff : '0;
   assign dec          = tick_ff && cur.armed && (cur.remaining != '0);
   assign new_rem      = dec ? (cur.remaining - DELAY_W'(1)) : cur.remaining;
   assign fire         = cur.armed && (new_rem == '0);
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign stall        = proc_valid_ff && fire && pend_valid_ff && !out_free;
   assign scan_done    = (scan_ptr_ff == PTR_W'(NUM_TIMERS)) && !proc_valid_ff;
   assign proc_idx_ext = CMP_W'(proc_idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_action == ACT_POLL || req_action == ACT_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sweep control, memory accesses and response staging
   always_comb begin
      scan_ptr_in   = scan_ptr_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      tick_in       = tick_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = proc_idx_ff;
      mem_we        = 1'b0;
      mem_waddr     = req_idx_ext[ADDR_W-1:0];
      mem_wdata     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  ACT_SET: begin
                     mem_we    = req_idx_ok;
                     mem_wdata = '{armed: 1'b1, remaining: req_chan.delay_ticks};
                  end
                  ACT_CLEAR: begin
                     mem_we    = req_idx_ok;
                     mem_wdata = '0;
                  end
                  default: begin
                     scan_ptr_in   = '0;
                     proc_valid_in = 1'b0;
                     tick_in       = (req_action == ACT_TICK);
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read side: advance unless the entry in hand is held
            if (!stall) begin
               if (scan_ptr_ff != PTR_W'(NUM_TIMERS)) begin
                  rd_addr       = scan_ptr_ff[ADDR_W-1:0];
                  proc_valid_in = 1'b1;
                  proc_idx_in   = scan_ptr_ff[ADDR_W-1:0];
                  scan_ptr_in   = scan_ptr_ff + PTR_W'(1);
               end else begin
                  proc_valid_in = 1'b0;
               end
            end
            // write-back side: decrement, disarm on expiry
            if (proc_valid_ff && !stall) begin
               mem_we    = 1'b1;
               mem_waddr = proc_idx_ff;
               mem_wdata = '{armed: cur.armed && !fire, remaining: new_rem};
               if (fire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = pend_idx_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = proc_idx_ext[INDEX_W-1:0];
               end
            end
         end
         ST_FLUSH: begin
            // the held expiry is the final one of this sweep
            if (pend_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = pend_idx_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            proc_valid_in = 1'b0;
         end
      endcase
   end

   // timer memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[rd_addr];
      rd_vld_ff    <= ent_valid_ff[rd_addr];
   end

   // valid flags: cleared by reset, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
      end else if (mem_we) begin
         ent_valid_ff[mem_waddr] <= 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ptr_ff   <= '0;
         proc_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tick_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ptr_ff   <= scan_ptr_in;
         proc_valid_ff <= proc_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         tick_ff       <= tick_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      proc_idx_ff  <= proc_idx_in;
      pend_idx_ff  <= pend_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // checks
   `include "assert_macros.svh"

   `ASSERT_IMPLIES(a_no_pend_idle, clock, reset, state_ff == ST_IDLE, !pend_valid_ff && !proc_valid_ff)
   `ASSERT_NEXT(a_stall_holds, clock, reset, state_ff == ST_SCAN && stall, proc_valid_ff && $stable(proc_idx_ff))
   `ASSERT_IMPLIES(a_ptr_range, clock, reset, state_ff == ST_SCAN, scan_ptr_ff <= PTR_W'(NUM_TIMERS))

endmodule
